// File: sv/best_fit_partition_allocator_macros.svh
// Assertion macros used by the allocator top level.
// Depends on nothing; taken in by the top level, which checks its own logic.
`ifndef BEST_FIT_PARTITION_ALLOCATOR_MACROS_SVH
`define BEST_FIT_PARTITION_ALLOCATOR_MACROS_SVH

// Check a property on every rising edge outside reset, with a fixed message.
`define BFPA_ASSERT(name, clk, rst_n, prop) \
  name: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("bfpa assertion failed");

// Same, with a caller-supplied message string.
`define BFPA_ASSERT_MSG(name, clk, rst_n, prop, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error(msg);

`endif

// File: sv/bfpa_pkg.sv
// Shared types and fixed widths of the best-fit partition allocator.
// Depends on nothing; used by scoped names by every module of the block but bfpa_store.
`default_nettype none

package bfpa_pkg;

  localparam int unsigned SlotW   = 3;
  localparam int unsigned AmountW = 16;
  localparam int unsigned ChosenW = 3;
  localparam int unsigned StartW  = 19;
  localparam int unsigned EndW    = 20;
  localparam int unsigned LeftW   = 16;

  // Item kinds
  localparam logic KIND_LOAD    = 1'b0;
  localparam logic KIND_REQUEST = 1'b1;

  typedef struct packed {
    logic               kind;
    logic [SlotW-1:0]   slot;
    logic [AmountW-1:0] amount;
  } in_beat_t;

  typedef struct packed {
    logic                   granted;
    logic [ChosenW-1:0]     chosen;
    logic [StartW-1:0]      start_address;
    logic signed [EndW-1:0] end_address;
    logic [LeftW-1:0]       leftover;
  } out_beat_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LOAD,
    ST_SCAN,
    ST_DRAIN,
    ST_CALC,
    ST_DONE
  } state_e;

  // Strobes from the sequencer to the datapath
  typedef struct packed {
    logic clear;   // item accepted: restart the scan
    logic scan;    // a partition read is issued this cycle
    logic load;    // write a partition size
    logic calc;    // form the grant and write back free space
    logic finish;  // move the result into the output register
  } ctrl_t;

endpackage

`default_nettype wire

// File: sv/bfpa_store.sv
// Partition size and free-space memories with per-entry valid bits.
// Uses no package; its widths come in as parameters from the instantiating module.
`default_nettype none

module bfpa_store #(
  parameter int unsigned NUM_PARTITIONS = 8,
  parameter int unsigned SIZE_BITS      = 16,
  localparam int unsigned IdxW = (NUM_PARTITIONS > 1) ? $clog2(NUM_PARTITIONS) : 1
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic [IdxW-1:0]      rd_addr_i,
  input  wire logic [IdxW-1:0]      wr_addr_i,
  input  wire logic                 wr_full_en_i,
  input  wire logic                 wr_free_en_i,
  input  wire logic [SIZE_BITS-1:0] wr_full_i,
  input  wire logic [SIZE_BITS-1:0] wr_free_i,
  output logic      [SIZE_BITS-1:0] rd_full_o,
  output logic      [SIZE_BITS-1:0] rd_free_o
);

  logic [SIZE_BITS-1:0]      full_mem [NUM_PARTITIONS];
  logic [SIZE_BITS-1:0]      free_mem [NUM_PARTITIONS];
  logic [NUM_PARTITIONS-1:0] vld_q;
  logic [SIZE_BITS-1:0]      rd_full_q;
  logic [SIZE_BITS-1:0]      rd_free_q;

  // A size write marks the entry live; unwritten entries read as zero.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (wr_full_en_i) begin
      vld_q[wr_addr_i] <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_full_en_i) begin
      full_mem[wr_addr_i] <= wr_full_i;
    end
    if (wr_free_en_i) begin
      free_mem[wr_addr_i] <= wr_free_i;
    end
  end

  always_ff @(posedge clk_i) begin
    rd_full_q <= vld_q[rd_addr_i] ? full_mem[rd_addr_i] : '0;
    rd_free_q <= vld_q[rd_addr_i] ? free_mem[rd_addr_i] : '0;
  end

  assign rd_full_o = rd_full_q;
  assign rd_free_o = rd_free_q;

endmodule

`default_nettype wire

// File: sv/bfpa_fit_unit.sv
// Shared compare/accumulate unit: walks the partitions one per cycle,
// tracks the best fit and the running base address. Uses bfpa_pkg.
`default_nettype none

module bfpa_fit_unit #(
  parameter int unsigned NUM_PARTITIONS = 8,
  parameter int unsigned SIZE_BITS      = 16,
  localparam int unsigned IdxW = (NUM_PARTITIONS > 1) ? $clog2(NUM_PARTITIONS) : 1
) (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire bfpa_pkg::ctrl_t             ctrl_i,
  input  wire logic [IdxW-1:0]             scan_idx_i,
  input  wire logic [SIZE_BITS-1:0]        amt_i,
  input  wire logic [SIZE_BITS-1:0]        rd_full_i,
  input  wire logic [SIZE_BITS-1:0]        rd_free_i,
  output logic                             found_o,
  output logic      [IdxW-1:0]             best_idx_o,
  output logic      [SIZE_BITS-1:0]        best_full_o,
  output logic      [SIZE_BITS-1:0]        best_free_o,
  output logic      [bfpa_pkg::StartW-1:0] best_base_o
);

  localparam int unsigned StartW = bfpa_pkg::StartW;

  logic                          vld_q;
  logic [IdxW-1:0]               idx_q;
  logic                          found_q;
  logic [IdxW-1:0]               best_idx_q;
  logic [SIZE_BITS-1:0]          best_full_q;
  logic [SIZE_BITS-1:0]          best_free_q;
  logic [StartW-1:0]             best_base_q;
  logic [StartW-1:0]             base_acc_q;
  logic [StartW-1:0]             base_acc_d;
  logic [SIZE_BITS+StartW-1:0]   full_wide;
  logic                          take;

  // Fits, and strictly smaller than the best so far (lowest index wins ties).
  assign take = vld_q && (rd_free_i >= amt_i) && (!found_q || (rd_free_i < best_free_q));

  assign full_wide  = {{StartW{1'b0}}, rd_full_i};
  assign base_acc_d = base_acc_q + full_wide[StartW-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q   <= 1'b0;
      found_q <= 1'b0;
    end else begin
      vld_q <= ctrl_i.scan;
      if (ctrl_i.clear) begin
        found_q <= 1'b0;
      end else if (take) begin
        found_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    idx_q <= scan_idx_i;
    if (ctrl_i.clear) begin
      base_acc_q <= '0;
    end else if (vld_q) begin
      base_acc_q <= base_acc_d;
    end
    if (take) begin
      best_idx_q  <= idx_q;
      best_full_q <= rd_full_i;
      best_free_q <= rd_free_i;
      best_base_q <= base_acc_q;
    end
  end

  assign found_o     = found_q;
  assign best_idx_o  = best_idx_q;
  assign best_full_o = best_full_q;
  assign best_free_o = best_free_q;
  assign best_base_o = best_base_q;

endmodule

`default_nettype wire

// File: sv/bfpa_ctrl.sv
// Sequencer of the allocator: item handshake, scan counter and datapath strobes.
// Uses bfpa_pkg for the state enum and the strobe struct.
`default_nettype none

module bfpa_ctrl #(
  parameter int unsigned NUM_PARTITIONS = 8,
  localparam int unsigned IdxW = (NUM_PARTITIONS > 1) ? $clog2(NUM_PARTITIONS) : 1
) (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            in_valid_i,
  input  wire logic            in_kind_i,
  input  wire logic            out_free_i,
  output logic                 in_stall_o,
  output logic      [IdxW-1:0] scan_idx_o,
  output bfpa_pkg::ctrl_t      ctrl_o
);

  localparam logic [IdxW-1:0] LastIdx = IdxW'(NUM_PARTITIONS - 1);

  bfpa_pkg::state_e state_q, state_d;
  logic [IdxW-1:0]  idx_q, idx_d;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      bfpa_pkg::ST_IDLE: begin
        if (in_valid_i) begin
          state_d = (in_kind_i == bfpa_pkg::KIND_REQUEST) ? bfpa_pkg::ST_SCAN
                                                          : bfpa_pkg::ST_LOAD;
        end
      end
      bfpa_pkg::ST_LOAD:  state_d = bfpa_pkg::ST_DONE;
      bfpa_pkg::ST_SCAN: begin
        if (idx_q == LastIdx) begin
          state_d = bfpa_pkg::ST_DRAIN;
        end
      end
      bfpa_pkg::ST_DRAIN: state_d = bfpa_pkg::ST_CALC;
      bfpa_pkg::ST_CALC:  state_d = bfpa_pkg::ST_DONE;
      bfpa_pkg::ST_DONE: begin
        if (out_free_i) begin
          state_d = bfpa_pkg::ST_IDLE;
        end
      end
      default: state_d = bfpa_pkg::ST_IDLE;
    endcase
  end

  assign idx_d = (state_q == bfpa_pkg::ST_SCAN) ? idx_q + IdxW'(1) : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= bfpa_pkg::ST_IDLE;
      idx_q   <= '0;
    end else begin
      state_q <= state_d;
      idx_q   <= idx_d;
    end
  end

  always_comb begin
    ctrl_o.clear  = (state_q == bfpa_pkg::ST_IDLE) && in_valid_i;
    ctrl_o.scan   = (state_q == bfpa_pkg::ST_SCAN);
    ctrl_o.load   = (state_q == bfpa_pkg::ST_LOAD);
    ctrl_o.calc   = (state_q == bfpa_pkg::ST_CALC);
    ctrl_o.finish = (state_q == bfpa_pkg::ST_DONE) && out_free_i;
    in_stall_o    = (state_q != bfpa_pkg::ST_IDLE);
  end

  assign scan_idx_o = idx_q;

endmodule

`default_nettype wire

// File: sv/best_fit_partition_allocator.sv
// Best-fit partition allocator, top level.
// Uses bfpa_pkg, bfpa_ctrl, bfpa_fit_unit, bfpa_store and the assertion macros.
//
// Usage:
//   Input channel (in_valid_i / in_stall_o / in_beat_i) carries one beat per
//   item. kind = load writes the size of partition 'slot' and empties it;
//   kind = request places 'amount' in the partition with the least free space
//   that still holds it, lowest index on a tie, taken from the front of its
//   free space. Output channel (out_valid_o / out_stall_i / out_beat_o)
//   returns exactly one beat per item, in order.
//   Partitions lie back to back: the base of partition i is the sum of the
//   sizes of partitions below it.
// Sequence:
//   A load passes from accept through LOAD and DONE. A request passes
//   through SCAN, DRAIN, CALC and DONE; the result enters the output
//   register as the item leaves DONE. The scan is done by the single
//   compare/accumulate unit that reads one partition per cycle from the store.
//   in_stall_o is high while an item is in flight.
// Reset: all partition sizes and free space read as zero; no beat pending.
// Output stall: the result waits in the output register; a finished item
//   that finds the register still full holds until it drains.
`default_nettype none

`include "best_fit_partition_allocator_macros.svh"

module best_fit_partition_allocator #(
  parameter int unsigned NUM_PARTITIONS = 8,
  parameter int unsigned SIZE_BITS      = 16
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                in_valid_i,
  output logic                     in_stall_o,
  input  wire bfpa_pkg::in_beat_t  in_beat_i,
  output logic                     out_valid_o,
  input  wire logic                out_stall_i,
  output bfpa_pkg::out_beat_t      out_beat_o
);

  localparam int unsigned IdxW     = (NUM_PARTITIONS > 1) ? $clog2(NUM_PARTITIONS) : 1;
  localparam int unsigned SlotW    = bfpa_pkg::SlotW;
  localparam int unsigned AmountW  = bfpa_pkg::AmountW;
  localparam int unsigned ChosenW  = bfpa_pkg::ChosenW;
  localparam int unsigned StartW   = bfpa_pkg::StartW;
  localparam int unsigned EndW     = bfpa_pkg::EndW;
  localparam int unsigned LeftW    = bfpa_pkg::LeftW;
  localparam int unsigned SlotCmpW = 7;  // holds the largest partition count
  localparam logic [SlotCmpW-1:0] NumPart = SlotCmpW'(NUM_PARTITIONS);

  bfpa_pkg::ctrl_t      ctrl_s;
  logic [IdxW-1:0]      scan_idx;
  logic                 out_free;

  // Accepted item
  logic [SlotW-1:0]     slot_q;
  logic [SIZE_BITS-1:0] amt_q;
  logic [SIZE_BITS+AmountW-1:0] amt_in_wide;

  // Store and fit unit
  logic [SIZE_BITS-1:0] rd_full, rd_free;
  logic                 found;
  logic [IdxW-1:0]      best_idx;
  logic [SIZE_BITS-1:0] best_full, best_free;
  logic [StartW-1:0]    best_base;

  // Grant arithmetic
  logic [SlotCmpW-1:0]          slot_wide;
  logic                         slot_ok;
  logic [IdxW+SlotW-1:0]        slot_idx_wide;
  logic [IdxW-1:0]              wr_addr;
  logic                         wr_full_en, wr_free_en;
  logic [SIZE_BITS-1:0]         wr_free;
  logic [SIZE_BITS-1:0]         used;
  logic [SIZE_BITS+StartW-1:0]  used_wide;
  logic [StartW-1:0]            start_d;
  logic [SIZE_BITS-1:0]         new_free;
  logic [SIZE_BITS+LeftW-1:0]   new_free_wide;
  logic [IdxW+ChosenW-1:0]      best_idx_wide;
  logic [SIZE_BITS+EndW-1:0]    amt_end_wide;
  logic [EndW-1:0]              end_sum;

  // Result held between the datapath and the output register
  logic                 res_granted_q;
  logic                 res_req_q;
  logic [ChosenW-1:0]   res_chosen_q;
  logic [StartW-1:0]    res_start_q;
  logic [LeftW-1:0]     res_left_q;

  logic                 out_valid_q;
  bfpa_pkg::out_beat_t  out_beat_q;

  assign out_free = !out_valid_q || !out_stall_i;

  bfpa_ctrl #(
    .NUM_PARTITIONS (NUM_PARTITIONS)
  ) u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_kind_i  (in_beat_i.kind),
    .out_free_i (out_free),
    .in_stall_o (in_stall_o),
    .scan_idx_o (scan_idx),
    .ctrl_o     (ctrl_s)
  );

  // Capture the item beat; mask or widen the amount to the partition size width.
  assign amt_in_wide = {{SIZE_BITS{1'b0}}, in_beat_i.amount};

  always_ff @(posedge clk_i) begin
    if (ctrl_s.clear) begin
      slot_q <= in_beat_i.slot;
      amt_q  <= amt_in_wide[SIZE_BITS-1:0];
    end
  end

  // Loads to a slot past the last partition are dropped.
  assign slot_wide     = SlotCmpW'(slot_q);
  assign slot_ok       = (slot_wide < NumPart);
  assign slot_idx_wide = {{IdxW{1'b0}}, slot_q};

  // Single write port: a load writes size and free space, a grant writes free space.
  assign wr_addr    = ctrl_s.load ? slot_idx_wide[IdxW-1:0] : best_idx;
  assign wr_full_en = ctrl_s.load && slot_ok;
  assign wr_free_en = (ctrl_s.load && slot_ok) || (ctrl_s.calc && found);
  assign wr_free    = ctrl_s.load ? amt_q : new_free;

  bfpa_store #(
    .NUM_PARTITIONS (NUM_PARTITIONS),
    .SIZE_BITS      (SIZE_BITS)
  ) u_store (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .rd_addr_i    (scan_idx),
    .wr_addr_i    (wr_addr),
    .wr_full_en_i (wr_full_en),
    .wr_free_en_i (wr_free_en),
    .wr_full_i    (amt_q),
    .wr_free_i    (wr_free),
    .rd_full_o    (rd_full),
    .rd_free_o    (rd_free)
  );

  bfpa_fit_unit #(
    .NUM_PARTITIONS (NUM_PARTITIONS),
    .SIZE_BITS      (SIZE_BITS)
  ) u_fit (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .ctrl_i      (ctrl_s),
    .scan_idx_i  (scan_idx),
    .amt_i       (amt_q),
    .rd_full_i   (rd_full),
    .rd_free_i   (rd_free),
    .found_o     (found),
    .best_idx_o  (best_idx),
    .best_full_o (best_full),
    .best_free_o (best_free),
    .best_base_o (best_base)
  );

  // Start = partition base + space already handed out in it.
  assign used          = best_full - best_free;
  assign used_wide     = {{StartW{1'b0}}, used};
  assign start_d       = best_base + used_wide[StartW-1:0];
  assign new_free      = best_free - amt_q;
  assign new_free_wide = {{LeftW{1'b0}}, new_free};
  assign best_idx_wide = {{ChosenW{1'b0}}, best_idx};

  always_ff @(posedge clk_i) begin
    if (ctrl_s.load) begin
      res_granted_q <= slot_ok;
      res_req_q     <= 1'b0;
      res_chosen_q  <= '0;
      res_start_q   <= '0;
      res_left_q    <= '0;
    end else if (ctrl_s.calc) begin
      res_granted_q <= found;
      res_req_q     <= found;
      res_chosen_q  <= found ? best_idx_wide[ChosenW-1:0] : '0;
      res_start_q   <= found ? start_d : '0;
      res_left_q    <= found ? new_free_wide[LeftW-1:0] : '0;
    end
  end

  // End = start + amount - 1, wrapping; -1 for a zero-size grant at address 0.
  assign amt_end_wide = {{EndW{1'b0}}, amt_q};
  assign end_sum      = EndW'(res_start_q) + amt_end_wide[EndW-1:0] - EndW'(1);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (ctrl_s.finish) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_s.finish) begin
      out_beat_q.granted       <= res_granted_q;
      out_beat_q.chosen        <= res_chosen_q;
      out_beat_q.start_address <= res_start_q;
      out_beat_q.end_address   <= res_req_q ? $signed(end_sum) : '0;
      out_beat_q.leftover      <= res_left_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_beat_o  = out_beat_q;

  // An accepted beat always closes the input side in the following cycle.
  `BFPA_ASSERT(a_one_item_in_flight, clk_i, rst_ni,
               (in_valid_i && !in_stall_o) |=> in_stall_o)
  // A result is only moved into the output register when it has room.
  `BFPA_ASSERT(a_finish_has_room, clk_i, rst_ni,
               ctrl_s.finish |-> (!out_valid_q || !out_stall_i))
  // The scan never addresses past the last partition.
  `BFPA_ASSERT(a_scan_in_range, clk_i, rst_ni,
               ctrl_s.scan |-> (32'(scan_idx) < 32'(NUM_PARTITIONS)))
  // A refused beat carries all-zero fields.
  `BFPA_ASSERT_MSG(a_refused_is_zero, clk_i, rst_ni,
                   (out_valid_o && !out_beat_o.granted) |->
                     (out_beat_o.chosen == '0 && out_beat_o.start_address == '0 &&
                      out_beat_o.end_address == '0 && out_beat_o.leftover == '0),
                   "refused beat has nonzero fields")

endmodule

`default_nettype wire

// File: test/best_fit_partition_allocator_tb.sv
// Self-checking testbench for the best-fit partition allocator.
// Depends on bfpa_pkg and best_fit_partition_allocator; predicts every grant
// with a local model and checks each output beat field by field.
`default_nettype none

module best_fit_partition_allocator_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import bfpa_pkg::*;

  localparam int unsigned NumSlots    = 8;
  localparam int unsigned TargetItems = 1200;
  // Hold the output stall for a stretch while the sender keeps offering beats,
  // so the block backs up and stalls its input.
  localparam int unsigned HoldStart   = 1500;
  localparam int unsigned HoldEnd     = 1800;
  // Neither side idles inside this window.
  localparam int unsigned BusyStart   = 4000;
  localparam int unsigned BusyEnd     = 7000;
  localparam int unsigned IdlePct     = 24;
  localparam int unsigned DrainCycles = 24;

  logic      clk_i       = 1'b0;
  logic      rst_ni      = 1'b0;
  logic      in_valid_i  = 1'b0;
  logic      in_stall_o;
  in_beat_t  in_beat_i   = '0;
  logic      out_valid_o;
  logic      out_stall_i = 1'b0;
  out_beat_t out_beat_o;

  // Local picture of the partition table, updated as each beat is accepted.
  logic [AmountW-1:0] part_size [NumSlots];
  logic [AmountW-1:0] part_free [NumSlots];

  in_beat_t  pending_beats[$];
  out_beat_t expected_grants[$];
  int unsigned mismatches = 0;
  int unsigned sender_cycle = 0;
  int unsigned receiver_cycle = 0;

  best_fit_partition_allocator #(
    .NUM_PARTITIONS(NumSlots),
    .SIZE_BITS     (AmountW)
  ) DUT (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_beat_i  (in_beat_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_beat_o (out_beat_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Apply one beat to the partition table and return the grant it yields.
  // A load resizes and empties its partition. A request goes to the fitting
  // partition with the least free space, lowest index on a tie, and is carved
  // from the front of that partition's free space.
  function automatic out_beat_t best_fit_outcome(in_beat_t beat);
    out_beat_t          grant;
    logic               found;
    int unsigned        pick;
    logic [StartW-1:0]  base;
    logic [AmountW-1:0] need;
    grant = '0;
    need  = beat.amount;
    if (beat.kind == KIND_LOAD) begin
      part_size[beat.slot] = need;
      part_free[beat.slot] = need;
      grant.granted = 1'b1;
      return grant;
    end
    found = 1'b0;
    pick  = 0;
    for (int p = 0; p < NumSlots; p++) begin
      if (part_free[p] >= need && (!found || part_free[p] < part_free[pick])) begin
        pick  = p;
        found = 1'b1;
      end
    end
    // No fit: the table stays as it is and the grant is all zero.
    if (!found) return grant;
    base = '0;
    for (int p = 0; p < pick; p++) base += StartW'(part_size[p]);
    base += StartW'(AmountW'(part_size[pick] - part_free[pick]));
    part_free[pick] = part_free[pick] - need;
    grant.granted       = 1'b1;
    grant.chosen        = ChosenW'(pick);
    grant.start_address = base;
    // A zero-size request ends one below its start, -1 at address zero.
    grant.end_address   = EndW'(base) + EndW'(need) - EndW'(1);
    grant.leftover      = part_free[pick];
    return grant;
  endfunction

  task automatic check_field(string field, int unsigned want, int unsigned got);
    if (want != got) begin
      $error("%s: expected 0x%0h, got 0x%0h", field, want, got);
      mismatches++;
    end
  endtask

  // Sender: hold a stalled beat, advance once it is accepted, idle at random.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
      in_beat_i  <= '0;
      for (int p = 0; p < NumSlots; p++) begin
        part_size[p] = '0;
        part_free[p] = '0;
      end
    end else begin
      sender_cycle++;
      if (!in_valid_i || !in_stall_o) begin
        // The beat on the bus (if any) is taken at this edge: predict it now.
        if (in_valid_i) expected_grants.push_back(best_fit_outcome(in_beat_i));
        if (pending_beats.size() != 0 &&
            (sender_cycle >= BusyStart && sender_cycle < BusyEnd ||
             $urandom_range(0, 99) >= IdlePct)) begin
          in_valid_i <= 1'b1;
          in_beat_i  <= pending_beats.pop_front();
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // Receiver: check each accepted beat against the oldest prediction, then
  // pick the stall for the next cycle. Hold the stall for a long stretch once
  // so the block fills up and pushes back on the sender.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
    end else begin
      receiver_cycle++;
      if (out_valid_o && !out_stall_i) begin
        if (expected_grants.size() == 0) begin
          $error("unexpected output beat: 0x%0h", out_beat_o);
          mismatches++;
        end else begin
          out_beat_t want;
          want = expected_grants.pop_front();
          check_field("granted", want.granted, out_beat_o.granted);
          check_field("chosen", want.chosen, out_beat_o.chosen);
          check_field("start_address", want.start_address, out_beat_o.start_address);
          check_field("end_address", want.end_address, out_beat_o.end_address);
          check_field("leftover", want.leftover, out_beat_o.leftover);
        end
      end
      if (receiver_cycle >= HoldStart && receiver_cycle < HoldEnd)
        out_stall_i <= 1'b1;
      else if (receiver_cycle >= BusyStart && receiver_cycle < BusyEnd)
        out_stall_i <= 1'b0;
      else
        out_stall_i <= ($urandom_range(0, 99) < IdlePct);
    end
  end

  function automatic in_beat_t make_beat(logic kind, int unsigned slot,
                                         int unsigned amount);
    in_beat_t beat;
    beat.kind   = kind;
    beat.slot   = SlotW'(slot);
    beat.amount = AmountW'(amount);
    return beat;
  endfunction

  // Size spread over all magnitudes so small and full-width values both occur.
  function automatic int unsigned spread_amount();
    return $urandom_range(0, (1 << $urandom_range(1, AmountW)) - 1);
  endfunction

  initial begin
    int unsigned roll;
    // Directed part: empty table, exact and tied fits, extremes, reloads.
    pending_beats.push_back(make_beat(KIND_REQUEST, 0, 0));      // zero size, empty table
    pending_beats.push_back(make_beat(KIND_REQUEST, 5, 1));      // nothing fits
    pending_beats.push_back(make_beat(KIND_LOAD, 0, 100));
    pending_beats.push_back(make_beat(KIND_LOAD, 1, 16'hFFFF));
    pending_beats.push_back(make_beat(KIND_LOAD, 2, 40));
    pending_beats.push_back(make_beat(KIND_LOAD, 3, 40));
    pending_beats.push_back(make_beat(KIND_LOAD, 4, 0));
    pending_beats.push_back(make_beat(KIND_LOAD, 5, 1));
    pending_beats.push_back(make_beat(KIND_LOAD, 6, 7));
    pending_beats.push_back(make_beat(KIND_LOAD, 7, 16'hFFFF));
    pending_beats.push_back(make_beat(KIND_REQUEST, 7, 40));     // tie, lower slot wins
    pending_beats.push_back(make_beat(KIND_REQUEST, 0, 40));
    pending_beats.push_back(make_beat(KIND_REQUEST, 3, 0));      // zero size, mid table
    pending_beats.push_back(make_beat(KIND_REQUEST, 0, 16'hFFFF));
    pending_beats.push_back(make_beat(KIND_REQUEST, 0, 16'hFFFF));
    pending_beats.push_back(make_beat(KIND_REQUEST, 0, 16'hFFFF)); // all full
    pending_beats.push_back(make_beat(KIND_REQUEST, 2, 1));
    pending_beats.push_back(make_beat(KIND_REQUEST, 6, 8));
    pending_beats.push_back(make_beat(KIND_LOAD, 1, 16'hFFFF));  // reload forgets grants
    pending_beats.push_back(make_beat(KIND_REQUEST, 0, 16'hAAAA));
    pending_beats.push_back(make_beat(KIND_REQUEST, 7, 16'h5555));
    pending_beats.push_back(make_beat(KIND_LOAD, 0, 16'hFFFF));
    pending_beats.push_back(make_beat(KIND_REQUEST, 0, 16'hFFFF));
    // Random part: mostly requests, with reloads often enough to keep grants
    // coming; a few zero-size and full-width requests mixed in.
    for (int n = 0; n < TargetItems; n++) begin
      roll = $urandom_range(0, 99);
      if (roll < 14)
        pending_beats.push_back(make_beat(KIND_LOAD, $urandom_range(0, NumSlots - 1),
                                          spread_amount()));
      else if (roll < 19)
        pending_beats.push_back(make_beat(KIND_REQUEST, $urandom, 0));
      else if (roll < 22)
        pending_beats.push_back(make_beat(KIND_REQUEST, $urandom, 16'hFFFF));
      else
        pending_beats.push_back(make_beat(KIND_REQUEST, $urandom, spread_amount()));
    end

    repeat (4) @(posedge clk_i);
    @(negedge clk_i) rst_ni = 1'b1;

    // Drain: every beat sent, every grant seen, then a quiet tail that would
    // catch a stray extra output beat.
    while (pending_beats.size() != 0 || in_valid_i) @(posedge clk_i);
    while (expected_grants.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  initial begin
    #5ms;
    $display("tb: failure");
    $finish;
  end

endmodule

`default_nettype wire
